// ----- sv/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants for the homing projectile step block.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned SPD_W  = 32;
  localparam int unsigned SUMSQ_W = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned UNIT_W = 31;
  localparam int unsigned TRAV_W = 40;
  localparam int unsigned MAG_W  = 35;

  localparam logic [SPD_W-1:0] SPEED_RESET = 32'd65536;

  localparam logic MODE_LAUNCH = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LAUNCH = 4'd1,
    OP_DIFF   = 4'd2,
    OP_NORM   = 4'd3,
    OP_SQ     = 4'd4,
    OP_SQRT   = 4'd5,
    OP_DIV    = 4'd6,
    OP_MOVE   = 4'd7,
    OP_HIT    = 4'd8
  } hps_op_t;

  typedef struct packed {
    hps_op_t    op;
    logic [1:0] axis;
    logic       load;
  } hps_cmd_t;

  typedef struct packed {
    logic zero_dir;
    logic norm_done;
    logic iter_done;
    logic mode;
  } hps_sts_t;

endpackage

// ----- sv/homing_projectile_step.sv -----
// ----------------------------------------------------------------------------
// homing_projectile_step
// Moves a Q16.16 projectile toward a target and tests it against the box.
//
//  channel | dir | payload
//  in_     | in  | tuser: mode; tdata: time, target, box min, box max
//  out_    | out | tuser: still_flying; tdata: x, y, z
//  cfg_    | in  | flight_speed
//
// Result valid the cycle after a launch transfer; a zero-direction step goes
// straight to the hit test; otherwise up to 30 normalise shifts, a bit-serial
// root and three bit-serial divides (one bit a cycle) dominate.
// Synchronous active-low reset clears position to zero and speed to 1.0.
// The input is held off while an item is in progress or its result waits;
// in_tready returns the cycle after the output transfer.
// ----------------------------------------------------------------------------
module homing_projectile_step import hps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [311:0] in_tdata,  // elapsed_time, target_x/y/z, box_min_x/y/z, box_max_x/y/z
  input  logic         in_tuser,  // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata, // out_x, out_y, out_z
  output logic         out_tuser, // still_flying
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  logic [SPD_W-1:0]        speed_r;
  logic                    busy, in_fire, out_fire;
  hps_cmd_t                cmd;
  hps_sts_t                sts, sts_core;
  logic signed [POS_W-1:0] tgt [3];
  logic signed [POS_W-1:0] bmin [3];
  logic signed [POS_W-1:0] bmax [3];
  logic signed [POS_W-1:0] pos [3];
  logic                    flying;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) speed_r <= SPEED_RESET;
    else if (cfg_we) speed_r <= cfg_wdata;
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign tgt[i]  = in_tdata[24 + 32*i +: 32];
    assign bmin[i] = in_tdata[120 + 32*i +: 32];
    assign bmax[i] = in_tdata[216 + 32*i +: 32];
  end

  always_comb begin
    sts      = sts_core;
    sts.mode = in_tuser;
  end

  hps_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .busy, .out_valid(out_tvalid)
  );

  hps_dpath u_dpath (
    .clk, .rst_n, .in_fire, .time_i(in_tdata[23:0]), .tgt_i(tgt), .bmin_i(bmin),
    .bmax_i(bmax), .speed(speed_r), .cmd, .sts_core, .flying, .pos
  );

  assign out_tdata = {pos[2], pos[1], pos[0]};
  assign out_tuser = flying;

endmodule

// ----- sv/hps_ctrl.sv -----
// ----------------------------------------------------------------------------
// hps_ctrl
// Sequencer for one item: launch, or diff, normalise, squares, root, three
// divides, three moves and the hit test.
// ----------------------------------------------------------------------------
module hps_ctrl import hps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  hps_sts_t sts,
  output hps_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_NORM = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_MOVE = 9'b001000000,
    S_HIT  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       start_r, start_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    start_nxt = 1'b0;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    cmd.load  = start_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (sts.mode == MODE_STEP) begin
            state_nxt = S_DIFF;
          end else begin
            cmd.op    = OP_LAUNCH;
            state_nxt = S_OUT;
          end
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.zero_dir) begin
          state_nxt = S_HIT;
        end else begin
          cmd.op = OP_NORM;
          if (sts.norm_done) begin
            state_nxt = S_SQ;
            axis_nxt  = 2'd0;
          end
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (axis_r == 2'd2) begin
          state_nxt = S_SQRT;
          start_nxt = 1'b1;
          axis_nxt  = 2'd0;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (!start_r && sts.iter_done) begin
          state_nxt = S_DIV;
          start_nxt = 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (!start_r && sts.iter_done) begin
          if (axis_r == 2'd2) begin
            state_nxt = S_MOVE;
            axis_nxt  = 2'd0;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            start_nxt = 1'b1;
          end
        end
      end
      S_MOVE: begin
        cmd.op = OP_MOVE;
        if (axis_r == 2'd2) begin
          state_nxt = S_HIT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_HIT: begin
        cmd.op    = OP_HIT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 2'd0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      start_r <= start_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ----- sv/hps_dpath.sv -----
// ----------------------------------------------------------------------------
// hps_dpath
// Position registers, difference, normalise shifter, shared 32x32 multiplier,
// bit-serial root and divider, saturating move and box test.
// ----------------------------------------------------------------------------
module hps_dpath import hps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_fire,
  input  logic [TIME_W-1:0]       time_i,
  input  logic signed [POS_W-1:0] tgt_i [3],
  input  logic signed [POS_W-1:0] bmin_i [3],
  input  logic signed [POS_W-1:0] bmax_i [3],
  input  logic [SPD_W-1:0]        speed,
  input  hps_cmd_t                cmd,
  output hps_sts_t                sts_core,
  output logic                    flying,
  output logic signed [POS_W-1:0] pos [3]
);

  logic signed [POS_W-1:0]  pos_r [3];
  logic signed [POS_W-1:0]  tgt_r [3];
  logic signed [POS_W-1:0]  bmin_r [3];
  logic signed [POS_W-1:0]  bmax_r [3];
  logic [TIME_W-1:0]        time_r;
  logic [2:0]               neg_r;
  logic [ROOT_W-1:0]        a_r [3];
  logic [SUMSQ_W-1:0]       acc_r;
  logic [ROOT_W-1:0]        root_r;
  logic [UNIT_W-1:0]        unit_r [3];
  logic [TRAV_W-1:0]        trav_r;
  logic [SUMSQ_W-1:0]       rem_r;
  logic [SUMSQ_W-1:0]       num_r;
  logic [5:0]               cnt_r;
  logic                     flying_r;

  logic [ROOT_W-1:0] m_a, m_b;
  logic [63:0]       prod;
  logic [1:0]        ax;
  logic [ROOT_W-1:0] amax;

  assign ax   = cmd.axis;
  assign amax = a_r[0] | a_r[1] | a_r[2];
  assign prod = 64'(m_a) * 64'(m_b);

  always_comb begin
    m_a = a_r[ax];
    m_b = a_r[ax];
    if (cmd.op == OP_DIFF) begin
      m_a = speed;
      m_b = 32'(time_r);
    end
  end

  // move = min(floor(u*s/2^30), 2^34), u <= 2^30, s < 2^40
  logic [71:0]               mv_full;
  logic [MAG_W-1:0]          mag;
  logic signed [MAG_W+1:0]   sum;
  logic signed [POS_W-1:0]   sat;
  assign mv_full = 72'(unit_r[ax]) * 72'(trav_r);

  always_comb begin
    if (mv_full[71:30] > 42'(35'h4_0000_0000)) mag = 35'h4_0000_0000;
    else mag = mv_full[64:30];
    if (neg_r[ax]) sum = 37'(pos_r[ax]) - $signed({2'b00, mag});
    else           sum = 37'(pos_r[ax]) + $signed({2'b00, mag});
    if (sum > 37'sh0_7FFF_FFFF)       sat = 32'sh7FFF_FFFF;
    else if (sum < -37'sh0_8000_0000) sat = -32'sh8000_0000;
    else                              sat = sum[31:0];
  end

  // bit-serial iterations
  logic [SUMSQ_W-1:0] sq_trial;
  logic [SUMSQ_W-1:0] rem_sh;
  logic [SUMSQ_W-1:0] dv_rem;
  logic               dv_ge;
  always_comb begin
    rem_sh   = {rem_r[SUMSQ_W-3:0], acc_r[SUMSQ_W-1 -: 2]};
    sq_trial = 64'({root_r, 2'b01});
    dv_rem   = {rem_r[SUMSQ_W-2:0], num_r[SUMSQ_W-1]};
    dv_ge    = (dv_rem >= 64'(root_r));
  end

  logic signed [DIFF_W-1:0] d [3];
  logic [DIFF_W-1:0]        dm [3];
  logic                     big;
  logic                     in_box;
  logic signed [DIFF_W-1:0] lo_b [3];
  logic signed [DIFF_W-1:0] hi_b [3];

  // if any magnitude is 2^31 or more, all three are halved; the dropped bit stays dropped
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = 33'(tgt_r[i]) - 33'(pos_r[i]);
      dm[i] = d[i][DIFF_W-1] ? 33'(-d[i]) : d[i];
      if (dm[i][32:31] != 2'b00) big = 1'b1;
    end
  end

  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lo_b[i] = 33'(tgt_r[i]) + 33'(bmin_r[i]);
      hi_b[i] = 33'(tgt_r[i]) + 33'(bmax_r[i]);
      if (!(lo_b[i] <= 33'(pos_r[i]) && 33'(pos_r[i]) <= hi_b[i])) in_box = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      flying_r <= 1'b1;
    end else begin
      if (in_fire) begin
        tgt_r  <= tgt_i;
        bmin_r <= bmin_i;
        bmax_r <= bmax_i;
        time_r <= time_i;
      end
      case (cmd.op)
        OP_LAUNCH: begin
          pos_r    <= tgt_i;
          flying_r <= 1'b1;
        end
        OP_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= d[i][DIFF_W-1];
            a_r[i]   <= big ? dm[i][32:1] : dm[i][31:0];
          end
          trav_r <= prod[55:16];
          acc_r  <= '0;
        end
        OP_NORM: begin
          if (amax[31:30] == 2'b00) begin
            for (int i = 0; i < 3; i++) a_r[i] <= {a_r[i][30:0], 1'b0};
          end
        end
        OP_SQ: begin
          acc_r <= acc_r + prod;
          if (cmd.axis == 2'd2) begin
            root_r <= '0;
            rem_r  <= '0;
            cnt_r  <= 6'd32;
          end
        end
        OP_SQRT: begin
          if (!cmd.load && cnt_r != 6'd0) begin
            acc_r <= {acc_r[SUMSQ_W-3:0], 2'b00};
            if (rem_sh >= sq_trial) begin
              rem_r  <= rem_sh - sq_trial;
              root_r <= {root_r[ROOT_W-2:0], 1'b1};
            end else begin
              rem_r  <= rem_sh;
              root_r <= {root_r[ROOT_W-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 6'd1;
          end
        end
        OP_DIV: begin
          if (cmd.load) begin
            num_r <= {a_r[ax], 32'd0};
            rem_r <= '0;
            cnt_r <= 6'd62;
          end else if (cnt_r != 6'd0) begin
            num_r <= {num_r[SUMSQ_W-2:0], dv_ge};
            if (dv_ge) rem_r <= dv_rem - 64'(root_r);
            else       rem_r <= dv_rem;
            cnt_r <= cnt_r - 6'd1;
            if (cnt_r == 6'd1) unit_r[ax] <= {num_r[29:0], dv_ge};
          end
        end
        OP_MOVE: pos_r[ax] <= sat;
        OP_HIT:  flying_r  <= !in_box;
        default: ;
      endcase
    end
  end

  // normalisation is done when the largest magnitude reaches 2^30
  assign sts_core.zero_dir  = (amax == '0);
  assign sts_core.norm_done = (amax[31:30] != 2'b00);
  assign sts_core.iter_done = (cnt_r == 6'd0);
  assign sts_core.mode      = 1'b0;
  assign flying = flying_r;
  assign pos    = pos_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the homing projectile step block. Launch and step
// transfers are driven on the input stream, results are compared against an
// in-bench fixed-point predictor of position and box hit, under varied
// speeds, idling patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import hps_pkg::*;

  typedef struct packed {
    logic        flying;
    logic [31:0] x, y, z;
  } flight_res_t;

  typedef struct {
    logic        mode;
    logic [23:0] tm;
    logic signed [31:0] t[3];
    logic signed [31:0] bmin[3];
    logic signed [31:0] bmax[3];
  } flight_cmd_t;

  class flight_board;
    logic [31:0] speed;
    logic signed [31:0] pos[3];
    flight_res_t pending[$];
    int errors;

    function new();
      speed = SPEED_RESET;
      pos[0] = 0; pos[1] = 0; pos[2] = 0;
      errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(flight_cmd_t c);
      logic signed [34:0] d[3];
      logic [63:0] a[3];
      logic [63:0] m, len, u, s;
      logic [127:0] mv;
      logic signed [63:0] r, lo, hi;
      logic hit;
      flight_res_t e;
      hit = 1'b0;
      if (c.mode == MODE_LAUNCH) begin
        for (int i = 0; i < 3; i++) pos[i] = c.t[i];
      end else begin
        m = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = 35'(c.t[i]) - 35'(pos[i]);
          a[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
          if (a[i] > m) m = a[i];
        end
        if (m != 0) begin
          if (m >= 64'd1 << 31) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            m = m >> 1;
          end
          while (m < 64'd1 << 30) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            m = m << 1;
          end
          len = root64(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
          s = (64'(speed) * 64'(c.tm)) >> 16;
          for (int i = 0; i < 3; i++) begin
            u = (a[i] << 30) / len;
            mv = (128'(u) * 128'(s)) >> 30;
            if (mv > 128'd1 << 34) mv = 128'd1 << 34;
            r = d[i] < 0 ? 64'(pos[i]) - 64'(mv) : 64'(pos[i]) + 64'(mv);
            if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
            if (r < -64'sh80000000) r = -64'sh80000000;
            pos[i] = r[31:0];
          end
        end
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          lo = 64'(c.t[i]) + 64'(c.bmin[i]);
          hi = 64'(c.t[i]) + 64'(c.bmax[i]);
          if (!(lo <= 64'(pos[i]) && 64'(pos[i]) <= hi)) hit = 1'b0;
        end
      end
      e.flying = !hit;
      e.x = pos[0]; e.y = pos[1]; e.z = pos[2];
      pending.push_back(e);
    endfunction

    function void check_result(flight_res_t g);
      flight_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", g);
        return;
      end
      e = pending.pop_front();
      if (e !== g) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp fly=%0d x=%h y=%h z=%h got fly=%0d x=%h y=%h z=%h",
                   e.flying, e.x, e.y, e.z, g.flying, g.x, g.y, g.z);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready, in_tuser = 1'b0;
  logic [311:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0, out_tuser;
  logic [95:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  flight_board board = new();
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  always #6 clk = ~clk;

  homing_projectile_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_result({out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64]});
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic write_speed(logic [31:0] v);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.speed = v;
  endtask

  // tvalid stays high after a transfer until the next item or drain decides
  task automatic send_cmd(flight_cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.mode;
    in_tdata <= {c.bmax[2], c.bmax[1], c.bmax[0], c.bmin[2], c.bmin[1], c.bmin[0],
                 c.t[2], c.t[1], c.t[0], c.tm};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(c);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom_range(2047) - 1024;
      default: return $urandom;
    endcase
  endfunction

  function automatic flight_cmd_t rnd_cmd();
    flight_cmd_t c;
    logic signed [31:0] sz;
    c.mode = ($urandom_range(9) == 0) ? MODE_LAUNCH : MODE_STEP;
    c.tm = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(131072));
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(1)) c.t[i] = rnd_word();
      else c.t[i] = board.pos[i] + 32'($urandom_range(1 << 20)) - 32'(1 << 19);
      if ($urandom_range(3) == 0) begin
        c.bmin[i] = rnd_word();
        c.bmax[i] = rnd_word();
      end else begin
        sz = $urandom_range(1 << 22);
        c.bmin[i] = -sz;
        c.bmax[i] = sz;
      end
    end
    return c;
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) send_cmd(rnd_cmd());
  endtask

  initial begin
    flight_cmd_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: launches at extremes, zero direction, zero time, overshoot, inverted box
    c.tm = 24'hFFFFFF;
    for (int i = 0; i < 3; i++) begin
      c.t[i] = 0; c.bmin[i] = 32'h80000000; c.bmax[i] = 32'h7FFFFFFF;
    end
    c.mode = MODE_STEP; send_cmd(c);
    c.mode = MODE_LAUNCH;
    c.t[0] = 32'h7FFFFFFF; c.t[1] = 32'h80000000; c.t[2] = 32'h12345678; send_cmd(c);
    c.mode = MODE_STEP; send_cmd(c);
    c.t[0] = 32'h80000000; c.t[1] = 32'h7FFFFFFF; c.t[2] = 0; send_cmd(c);
    c.tm = 0; send_cmd(c);
    c.tm = 24'h010000; c.t[0] = 32'h00010000; send_cmd(c);
    c.bmin[0] = 5; c.bmax[0] = -5; send_cmd(c);
    c.mode = MODE_LAUNCH; c.t[0] = 0; c.t[1] = 0; c.t[2] = 0; send_cmd(c);
    c.mode = MODE_STEP; c.tm = 24'h008000;
    c.t[0] = 32'h00010000; c.t[1] = 32'h00010000; c.t[2] = -32'sh00010000;
    c.bmin[0] = 0; c.bmax[0] = 0; send_cmd(c);
    c.tm = 24'h800000; send_cmd(c);
    drain();

    write_speed(32'hFFFFFFFF);
    c.tm = 24'hFFFFFF; send_cmd(c);
    c.t[0] = 32'h80000000; send_cmd(c);
    drain();
    write_speed(32'd0);
    send_cmd(c);
    drain();
    write_speed(32'h00030000);

    send_idle = 21; recv_idle = 60;
    random_phase(300);
    hold_cycles = 3000;
    random_phase(30);
    drain();

    write_speed(32'h00008000);
    send_idle = 60; recv_idle = 21;
    random_phase(300);
    drain();

    write_speed($urandom);
    send_idle = 0; recv_idle = 0;
    random_phase(200);
    drain();
    write_speed(32'h00100000);
    random_phase(250);
    drain();

    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/hps_pkg.sv
sv/hps_ctrl.sv
sv/hps_dpath.sv
sv/homing_projectile_step.sv
dv/tb_top.sv
